// ===== rtl/core/rgbhsv_pkg.sv =====
package rgbhsv_pkg;

  localparam int CHAN_W = 8;
  // quotient bits per divider; both quotients fit in one channel width
  localparam int QUO_W  = CHAN_W;
  // dividend width of the dividers
  localparam int NUM_W  = CHAN_W + QUO_W;

  localparam int HUE_STEP     = 43;
  localparam int GREEN_OFFSET = 85;
  localparam int BLUE_OFFSET  = 171;
  localparam int FULL_SCALE   = 255;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [CHAN_W-1:0] hue;
    logic [CHAN_W-1:0] saturation;
    logic [CHAN_W-1:0] brightness;
  } hsv_t;

  typedef enum logic [1:0] {
    SECTOR_RED,
    SECTOR_GREEN,
    SECTOR_BLUE
  } sector_e;

  // data that rides alongside the dividers
  typedef struct packed {
    sector_e           sector;
    logic              neg;
    logic [CHAN_W-1:0] brightness;
  } side_t;

  // front end to dividers
  typedef struct packed {
    logic              valid;
    side_t             side;
    logic [CHAN_W-1:0] span;
    logic [NUM_W-1:0]  sat_num;
    logic [NUM_W-1:0]  hue_num;
  } prep_t;

  function automatic logic [CHAN_W-1:0] hue_offset(sector_e sector);
    logic [CHAN_W-1:0] offset;
    case (sector)
      SECTOR_RED:   offset = '0;
      SECTOR_GREEN: offset = CHAN_W'(GREEN_OFFSET);
      SECTOR_BLUE:  offset = CHAN_W'(BLUE_OFFSET);
      default:      offset = '0;
    endcase
    return offset;
  endfunction

endpackage

// ===== rtl/core/rgb_to_hsv_8bit_unit.sv =====
// Channel   Dir  Handshake                Beat
// --------  ---  -----------------------  -----------------------------------
// pixel     in   start_i high, busy_o low pixel_i: red, green, blue
// result    out  done_o strobe, 1 cycle   result_o: hue, saturation, brightness
//
// Fully pipelined: one beat may enter every cycle and busy_o is always low.
// Pipeline: 2 front-end stages (extrema, then the constant
// multiplies), 8 stages of the two restoring dividers running side by side
// (one quotient bit per stage), 1 output register.
// Reset clears the valid bits only; data registers are left as they are.
// The receiver cannot stall, so nothing is held back: each result shows on
// done_o for exactly one cycle.
module rgb_to_hsv_8bit_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  rgbhsv_pkg::pixel_t pixel_i,
  output logic               busy_o,
  output logic               done_o,
  output rgbhsv_pkg::hsv_t   result_o
);
  import rgbhsv_pkg::*;

  prep_t             prep;
  logic [QUO_W-1:0]  sat_quo;
  logic [QUO_W-1:0]  hue_quo;

  // sideband line, aligned with the divider stages
  logic [QUO_W-1:0]  sb_valid_q;
  side_t             sb_side_q [QUO_W];

  side_t             last_side;
  logic [CHAN_W-1:0] hue_signed;
  hsv_t              res_d;
  hsv_t              res_q;
  logic              done_q;

  rgbhsv_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i),
    .pixel_i (pixel_i),
    .prep_o  (prep)
  );

  // saturation = 255 * span / max
  rgbhsv_div #(
    .DenW (CHAN_W),
    .QuoW (QUO_W)
  ) u_div_sat (
    .clk_i (clk_i),
    .num_i (prep.sat_num),
    .den_i (prep.side.brightness),
    .quo_o (sat_quo)
  );

  // hue magnitude = 43 * |diff| / span, at most 43
  rgbhsv_div #(
    .DenW (CHAN_W),
    .QuoW (QUO_W)
  ) u_div_hue (
    .clk_i (clk_i),
    .num_i (prep.hue_num),
    .den_i (prep.span),
    .quo_o (hue_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_valid_q <= '0;
      done_q     <= 1'b0;
    end else begin
      sb_valid_q <= {sb_valid_q[QUO_W-2:0], prep.valid};
      done_q     <= sb_valid_q[QUO_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    sb_side_q[0] <= prep.side;
    for (int i = 1; i < QUO_W; i++) begin
      sb_side_q[i] <= sb_side_q[i-1];
    end
    res_q <= res_d;
  end

  assign last_side = sb_side_q[QUO_W-1];

  always_comb begin
    // truncation toward zero: negate the magnitude quotient
    hue_signed = last_side.neg ? CHAN_W'(-hue_quo) : CHAN_W'(hue_quo);

    res_d.brightness = last_side.brightness;
    res_d.saturation = CHAN_W'(sat_quo);
    res_d.hue        = hue_offset(last_side.sector) + hue_signed;

    // black pixel: divider by zero, force hue and saturation to 0
    if (last_side.brightness == '0) begin
      res_d.saturation = '0;
      res_d.hue        = '0;
    end else if (sat_quo == '0) begin
      // grey pixel
      res_d.hue = '0;
    end
  end

  assign busy_o   = 1'b0;
  assign done_o   = done_q;
  assign result_o = res_q;

  // grey or black pixels carry no hue
  a_grey_no_hue : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    done_o && (result_o.saturation == '0) |-> (result_o.hue == '0)
  ) else $error("hue set on a pixel without saturation");

  // black pixels carry no saturation
  a_black_no_sat : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    done_o && (result_o.brightness == '0) |-> (result_o.saturation == '0)
  ) else $error("saturation set on a black pixel");

  // a strobe comes only from a beat that left the sideband line
  a_done_from_line : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(sb_valid_q[QUO_W-1])
  ) else $error("result strobe without a beat in flight");

endmodule

// ===== rtl/core/rgbhsv_prep.sv =====
module rgbhsv_prep (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  rgbhsv_pkg::pixel_t pixel_i,
  output rgbhsv_pkg::prep_t  prep_o
);
  import rgbhsv_pkg::*;

  // stage A: extrema, sector, signed channel difference
  logic [CHAN_W-1:0] hi_d;
  logic [CHAN_W-1:0] lo_d;
  sector_e           sector_d;
  logic [CHAN_W:0]   diff_d;
  logic [CHAN_W-1:0] mag_d;

  logic              a_valid_q;
  side_t             a_side_q;
  logic [CHAN_W-1:0] a_span_q;
  logic [CHAN_W-1:0] a_mag_q;

  // stage B: scaled dividends
  logic              b_valid_q;
  side_t             b_side_q;
  logic [CHAN_W-1:0] b_span_q;
  logic [NUM_W-1:0]  b_sat_num_q;
  logic [NUM_W-1:0]  b_hue_num_q;

  always_comb begin
    // red wins ties, then green
    if (pixel_i.red >= pixel_i.green && pixel_i.red >= pixel_i.blue) begin
      sector_d = SECTOR_RED;
      hi_d     = pixel_i.red;
      diff_d   = {1'b0, pixel_i.green} - {1'b0, pixel_i.blue};
    end else if (pixel_i.green >= pixel_i.blue) begin
      sector_d = SECTOR_GREEN;
      hi_d     = pixel_i.green;
      diff_d   = {1'b0, pixel_i.blue} - {1'b0, pixel_i.red};
    end else begin
      sector_d = SECTOR_BLUE;
      hi_d     = pixel_i.blue;
      diff_d   = {1'b0, pixel_i.red} - {1'b0, pixel_i.green};
    end

    lo_d = pixel_i.red;
    if (pixel_i.green < lo_d) begin
      lo_d = pixel_i.green;
    end
    if (pixel_i.blue < lo_d) begin
      lo_d = pixel_i.blue;
    end

    mag_d = diff_d[CHAN_W] ? CHAN_W'(-diff_d) : diff_d[CHAN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_side_q.sector     <= sector_d;
    a_side_q.neg        <= diff_d[CHAN_W];
    a_side_q.brightness <= hi_d;
    a_span_q            <= hi_d - lo_d;
    a_mag_q             <= mag_d;

    b_side_q    <= a_side_q;
    b_span_q    <= a_span_q;
    b_sat_num_q <= NUM_W'(FULL_SCALE) * NUM_W'(a_span_q);
    b_hue_num_q <= NUM_W'(HUE_STEP) * NUM_W'(a_mag_q);
  end

  assign prep_o.valid   = b_valid_q;
  assign prep_o.side    = b_side_q;
  assign prep_o.span    = b_span_q;
  assign prep_o.sat_num = b_sat_num_q;
  assign prep_o.hue_num = b_hue_num_q;

endmodule

// ===== rtl/core/rgbhsv_div.sv =====
// Restoring divider, one quotient bit per register stage.
// Needs num_i < den_i * 2**QuoW; otherwise the quotient is meaningless.
module rgbhsv_div #(
  parameter int DenW = rgbhsv_pkg::CHAN_W,
  parameter int QuoW = rgbhsv_pkg::QUO_W
) (
  input  logic                 clk_i,
  input  logic [DenW+QuoW-1:0] num_i,
  input  logic [DenW-1:0]      den_i,
  output logic [QuoW-1:0]      quo_o
);
  localparam int NumW = DenW + QuoW;

  logic [NumW-1:0] rem_q [QuoW-1];
  logic [DenW-1:0] den_q [QuoW-1];
  logic [QuoW-1:0] quo_q [QuoW];

  for (genvar s = 0; s < QuoW; s++) begin : g_stage
    localparam int Bit = QuoW - 1 - s;

    logic [NumW-1:0] rem_in;
    logic [DenW-1:0] den_in;
    logic [QuoW-1:0] quo_in;
    logic [NumW-1:0] den_sh;
    logic            ge;

    if (s == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    assign den_sh = NumW'(den_in) << Bit;
    assign ge     = rem_in >= den_sh;

    always_ff @(posedge clk_i) begin
      quo_q[s] <= quo_in | (ge ? (QuoW'(1) << Bit) : '0);
    end

    if (s < QuoW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        rem_q[s] <= ge ? rem_in - den_sh : rem_in;
        den_q[s] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[QuoW-1];

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

// Pixel-stream check of rgb_to_hsv_8bit_unit. Pixels are queued up front by
// the stimulus block, presented in bursts by the driver and converted by a
// local HSV predictor on every accepted beat. The monitor compares each
// done_o beat with the oldest predicted result.
module testbench;
  import rgbhsv_pkg::*;

  localparam int CYCLE_LIMIT = 100000;
  localparam int DRAIN_CYCLES = 20;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   start_i = 1'b0;
  pixel_t pixel_i = '0;
  logic   busy_o;
  logic   done_o;
  hsv_t   result_o;

  pixel_t pixel_backlog[$];
  hsv_t   pending_hsv[$];
  int     burst_left = 0;
  int     gap_left = 0;
  int     cycle_count = 0;
  bit     failed = 1'b0;

  rgb_to_hsv_8bit_unit u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .pixel_i  (pixel_i),
    .busy_o   (busy_o),
    .done_o   (done_o),
    .result_o (result_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Expected HSV of one pixel. Ties for the maximum go to red, then green.
  // Division truncates toward zero; the hue sum wraps to 8 bits.
  function automatic hsv_t hsv_of(pixel_t px);
    int      r;
    int      g;
    int      b;
    int      hi;
    int      lo;
    int      span;
    int      diff;
    int      offset;
    int      sat;
    sector_e sector;
    hsv_t    res;
    r = int'(px.red);
    g = int'(px.green);
    b = int'(px.blue);
    hi = (r > g) ? r : g;
    hi = (hi > b) ? hi : b;
    lo = (r < g) ? r : g;
    lo = (lo < b) ? lo : b;
    span = hi - lo;
    res = '0;
    res.brightness = hi[CHAN_W-1:0];
    if (hi != 0) begin
      sat = (FULL_SCALE * span) / hi;
      res.saturation = sat[CHAN_W-1:0];
      // grey pixels keep hue at zero
      if (sat != 0 && span != 0) begin
        if (hi == r) begin
          sector = SECTOR_RED;
          diff = g - b;
        end else if (hi == g) begin
          sector = SECTOR_GREEN;
          diff = b - r;
        end else begin
          sector = SECTOR_BLUE;
          diff = r - g;
        end
        case (sector)
          SECTOR_GREEN: offset = GREEN_OFFSET;
          SECTOR_BLUE:  offset = BLUE_OFFSET;
          default:      offset = 0;
        endcase
        res.hue = CHAN_W'(offset + (HUE_STEP * diff) / span);
      end
    end
    return res;
  endfunction

  task automatic add_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    pixel_t px;
    px.red = r;
    px.green = g;
    px.blue = b;
    pixel_backlog.push_back(px);
  endtask

  // Driver: bursts of random length, random gaps in between; now and then a
  // long burst so that back-to-back beats are exercised too.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      pixel_i <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (start_i && !busy_o) begin
        pending_hsv.push_back(hsv_of(pixel_i));
      end
      // a beat held off by busy_o stays on the port unchanged
      if (!start_i || !busy_o) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          start_i <= 1'b0;
        end else if (pixel_backlog.size() != 0) begin
          start_i <= 1'b1;
          pixel_i <= pixel_backlog.pop_front();
          if (burst_left == 0) begin
            burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(0, 6);
            gap_left <= ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 5);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: every done_o beat must match the oldest prediction.
  always @(posedge clk_i) begin
    hsv_t want;
    if (rst_ni && done_o) begin
      if (pending_hsv.size() == 0) begin
        $display("%0t: unexpected result beat, got %h", $time, result_o);
        failed = 1'b1;
      end else begin
        want = pending_hsv.pop_front();
        if (result_o.hue !== want.hue) begin
          $display("%0t: hue expected %0d got %0d", $time, want.hue, result_o.hue);
          failed = 1'b1;
        end
        if (result_o.saturation !== want.saturation) begin
          $display("%0t: saturation expected %0d got %0d", $time, want.saturation,
                   result_o.saturation);
          failed = 1'b1;
        end
        if (result_o.brightness !== want.brightness) begin
          $display("%0t: brightness expected %0d got %0d", $time, want.brightness,
                   result_o.brightness);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    logic [7:0] va;
    logic [7:0] vb;
    logic [7:0] pick[5];
    pixel_t     px;
    int         i;

    // directed: black, greys, primaries, ties, wrap of negative hue
    add_pixel(8'd0, 8'd0, 8'd0);
    add_pixel(8'd255, 8'd255, 8'd255);
    add_pixel(8'd1, 8'd1, 8'd1);
    add_pixel(8'd128, 8'd128, 8'd128);
    add_pixel(8'd255, 8'd0, 8'd0);
    add_pixel(8'd0, 8'd255, 8'd0);
    add_pixel(8'd0, 8'd0, 8'd255);
    add_pixel(8'd255, 8'd255, 8'd0);    // red/green tie, red wins
    add_pixel(8'd0, 8'd255, 8'd255);    // green/blue tie, green wins
    add_pixel(8'd255, 8'd0, 8'd255);    // red/blue tie, hue wraps below zero
    add_pixel(8'd255, 8'd0, 8'd1);      // quotient truncates to zero
    add_pixel(8'd255, 8'd0, 8'd128);
    add_pixel(8'd255, 8'd254, 8'd254);  // span of one, lowest saturation
    add_pixel(8'd1, 8'd0, 8'd0);
    add_pixel(8'd0, 8'd10, 8'd20);      // blue sector, negative quotient
    add_pixel(8'd20, 8'd30, 8'd0);      // green sector, negative quotient
    add_pixel(8'd255, 8'd128, 8'd0);
    add_pixel(8'd0, 8'd1, 8'd255);
    add_pixel(8'd170, 8'd85, 8'd255);
    add_pixel(8'd85, 8'd170, 8'd0);

    // random: plain pixels, forced ties and values near the ends of the range
    for (i = 0; i < 1030; i++) begin
      va = 8'($urandom_range(0, 255));
      vb = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 3))
        1: begin
          case ($urandom_range(0, 3))
            0: add_pixel(va, va, vb);
            1: add_pixel(va, vb, va);
            2: add_pixel(vb, va, va);
            default: add_pixel(va, va, va);
          endcase
        end
        2: begin
          pick[0] = 8'd0;
          pick[1] = 8'd1;
          pick[2] = 8'd254;
          pick[3] = 8'd255;
          pick[4] = va;
          add_pixel(pick[$urandom_range(0, 4)], pick[$urandom_range(0, 4)],
                    pick[$urandom_range(0, 4)]);
        end
        default: begin
          px = pixel_t'(24'($urandom));
          pixel_backlog.push_back(px);
        end
      endcase
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pixel_backlog.size() != 0 || start_i || pending_hsv.size() != 0) begin
      @(posedge clk_i);
    end
    // let any stray beat surface past the pipeline depth
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (!failed) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
